// File: hdl/tbp_pkg.sv
package tbp_pkg;

	// table geometry
	localparam int unsigned TABLE_ENTRIES = 2048;
	localparam int unsigned IDX_W         = $clog2(TABLE_ENTRIES);
	localparam int unsigned HIST_W        = 11;
	localparam int unsigned HBITS_W       = 4;
	localparam int unsigned CTR_W         = 2;

	typedef logic [CTR_W-1:0]   ctr_t;
	typedef logic [IDX_W-1:0]   idx_t;
	typedef logic [HIST_W-1:0]  hist_t;
	typedef logic [HBITS_W-1:0] hbits_t;

	localparam ctr_t CTR_MAX       = ctr_t'(3);
	localparam ctr_t CTR_MIN       = ctr_t'(0);
	localparam ctr_t GSHARE_INIT   = CTR_MAX;  // strongly taken
	localparam ctr_t BIMODAL_INIT  = CTR_MAX;  // strongly taken
	localparam ctr_t CHOOSER_INIT  = CTR_MIN;  // strongly gshare
	localparam hbits_t HBITS_RESET = hbits_t'(HIST_W);

	// 2-bit saturating counter step
	function automatic ctr_t sat_step(input ctr_t c, input logic up);
		ctr_t r;
		if (up) begin
			r = (c == CTR_MAX) ? CTR_MAX : ctr_t'(c + ctr_t'(1));
		end else begin
			r = (c == CTR_MIN) ? CTR_MIN : ctr_t'(c - ctr_t'(1));
		end
		return r;
	endfunction

	// history mask for min(history_bits, HIST_W) low bits
	function automatic hist_t hist_mask(input hbits_t n);
		hist_t m;
		for (int i = 0; i < HIST_W; i++) begin
			m[i] = (n > hbits_t'(i));
		end
		return m;
	endfunction

	// gshare index: low address bits XOR history, folded into the table
	function automatic idx_t gshare_idx(input idx_t a, input hist_t h);
		idx_t r;
		for (int i = 0; i < IDX_W; i++) begin
			if (i < HIST_W) begin
				r[i] = a[i] ^ h[i];
			end else begin
				r[i] = a[i];
			end
		end
		return r;
	endfunction

endpackage

// File: hdl/tournament_branch_predictor.sv
// Tournament branch predictor: gshare and bimodal counter tables with a
// per-address chooser, trained on every resolved branch.
//
// Input channel (in_valid / in_stall): one transaction per resolved branch,
// carrying branch_address and taken. Output channel (out_valid / out_stall):
// one transaction per branch with the predictions made before the update
// and the correct flag. Configuration channel (cfg_valid / cfg_ready):
// writes history_bits; cfg_ready is always high, write only while idle.
//
// out_valid rises as the branch leaves the read stage: the table read is
// registered on the accepting edge, and the counter update then goes into
// the output register as the read stage advances. Throughput is one branch
// per cycle while nothing stalls; the three table RAMs each read and write
// once per cycle, with a one-entry bypass for the write on the read's edge.
//
// After reset a clearing pass writes all TABLE_ENTRIES (2048) rows of the
// three tables, one row per cycle; in_stall stays high until the pass ends.
// When the receiver stalls, the output register holds; one more branch can
// sit in the read stage, after which in_stall rises.
module tournament_branch_predictor
	import tbp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  history_bits,
	// branch input
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] branch_address,
	input  logic        taken,
	// prediction result
	output logic        out_valid,
	input  logic        out_stall,
	output logic        final_prediction,
	output logic        gshare_prediction,
	output logic        bimodal_prediction,
	output logic        chose_bimodal,
	output logic        prediction_correct
);

	// configuration and history
	hbits_t hbits_q;
	hist_t  hist_q;
	hist_t  mask;
	hist_t  hist_m;

	// clearing pass
	logic clearing_q;
	idx_t clr_idx_q;

	// read stage
	logic valid_s1;
	idx_t gidx_s1;
	idx_t bidx_s1;
	logic taken_s1;

	// bypass of the write made on the edge of the current read
	logic fwd_valid_q;
	idx_t fwd_gidx_q;
	idx_t fwd_bidx_q;
	ctr_t fwd_g_q;
	ctr_t fwd_b_q;
	ctr_t fwd_c_q;

	// output register
	logic out_valid_q;
	logic fpred_q;
	logic gpred_q;
	logic bpred_q;
	logic use_b_q;
	logic correct_q;

	logic in_fire;
	logic s1_adv;
	logic s1_fire;
	idx_t bidx_in;
	idx_t gidx_in;

	ctr_t g_rd, b_rd, c_rd;
	ctr_t gc, bc, cc;
	ctr_t g_new, b_new, c_new;
	logic gpred, bpred, use_b, fpred;
	logic gright, bright;

	logic we;
	idx_t g_waddr, b_waddr;
	ctr_t g_wdata, b_wdata, c_wdata;

	assign cfg_ready = 1'b1;

	// ---- handshakes ----
	assign s1_adv   = !out_valid_q || !out_stall;
	assign s1_fire  = valid_s1 && s1_adv;
	assign in_stall = clearing_q || (valid_s1 && !s1_adv);
	assign in_fire  = in_valid && !in_stall;

	// ---- index formation, from the ports and the live history ----
	assign mask    = hist_mask(hbits_q);
	assign hist_m  = hist_q & mask;
	assign bidx_in = branch_address[IDX_W-1:0];
	assign gidx_in = gshare_idx(bidx_in, hist_m);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hbits_q <= HBITS_RESET;
			hist_q  <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				hbits_q <= history_bits;
			end
			// history depends on the outcome only, so it moves on accept
			if (in_fire) begin
				hist_q <= {hist_m[HIST_W-2:0], taken} & mask;
			end
		end
	end

	// ---- clearing pass after reset ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (clearing_q) begin
			clr_idx_q <= idx_t'(clr_idx_q + idx_t'(1));
			if (clr_idx_q == idx_t'(TABLE_ENTRIES - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	// ---- table RAMs ----
	assign we      = clearing_q || s1_fire;
	assign g_waddr = clearing_q ? clr_idx_q : gidx_s1;
	assign b_waddr = clearing_q ? clr_idx_q : bidx_s1;
	assign g_wdata = clearing_q ? GSHARE_INIT : g_new;
	assign b_wdata = clearing_q ? BIMODAL_INIT : b_new;
	assign c_wdata = clearing_q ? CHOOSER_INIT : c_new;

	tbp_ram #(.WIDTH(CTR_W), .DEPTH(TABLE_ENTRIES)) u_gshare_ram (
		.clk   (clk),
		.we    (we),
		.waddr (g_waddr),
		.wdata (g_wdata),
		.re    (in_fire),
		.raddr (gidx_in),
		.rdata (g_rd)
	);

	tbp_ram #(.WIDTH(CTR_W), .DEPTH(TABLE_ENTRIES)) u_bimodal_ram (
		.clk   (clk),
		.we    (we),
		.waddr (b_waddr),
		.wdata (b_wdata),
		.re    (in_fire),
		.raddr (bidx_in),
		.rdata (b_rd)
	);

	tbp_ram #(.WIDTH(CTR_W), .DEPTH(TABLE_ENTRIES)) u_chooser_ram (
		.clk   (clk),
		.we    (we),
		.waddr (b_waddr),
		.wdata (c_wdata),
		.re    (in_fire),
		.raddr (bidx_in),
		.rdata (c_rd)
	);

	// ---- read stage ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			fwd_valid_q <= 1'b0;
		end else if (in_fire) begin
			valid_s1    <= 1'b1;
			// the RAM read misses a write on the same edge: keep it aside
			fwd_valid_q <= s1_fire;
		end else if (s1_fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			gidx_s1    <= gidx_in;
			bidx_s1    <= bidx_in;
			taken_s1   <= taken;
			fwd_gidx_q <= gidx_s1;
			fwd_bidx_q <= bidx_s1;
			fwd_g_q    <= g_new;
			fwd_b_q    <= b_new;
			fwd_c_q    <= c_new;
		end
	end

	// ---- counter update ----
	always_comb begin
		gc = (fwd_valid_q && (fwd_gidx_q == gidx_s1)) ? fwd_g_q : g_rd;
		bc = (fwd_valid_q && (fwd_bidx_q == bidx_s1)) ? fwd_b_q : b_rd;
		cc = (fwd_valid_q && (fwd_bidx_q == bidx_s1)) ? fwd_c_q : c_rd;

		gpred  = gc[CTR_W-1];
		bpred  = bc[CTR_W-1];
		use_b  = cc[CTR_W-1];
		fpred  = use_b ? bpred : gpred;
		gright = (gpred == taken_s1);
		bright = (bpred == taken_s1);

		g_new = sat_step(gc, taken_s1);
		b_new = sat_step(bc, taken_s1);
		// chooser trains only when exactly one side was right
		c_new = (gright != bright) ? sat_step(cc, bright) : cc;
	end

	// ---- output register ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			fpred_q   <= fpred;
			gpred_q   <= gpred;
			bpred_q   <= bpred;
			use_b_q   <= use_b;
			correct_q <= (fpred == taken_s1);
		end
	end

	assign out_valid          = out_valid_q;
	assign final_prediction   = fpred_q;
	assign gshare_prediction  = gpred_q;
	assign bimodal_prediction = bpred_q;
	assign chose_bimodal      = use_b_q;
	assign prediction_correct = correct_q;

endmodule

// File: hdl/tbp_ram.sv
module tbp_ram #(
	parameter int unsigned WIDTH = 2,
	parameter int unsigned DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// read returns the old contents on a same-address write
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
